/* rtl/csrmv_pkg.sv */
package csrmv_pkg;

   // Field widths fixed by the word formats.
   localparam int KIND_WIDTH   = 2;
   localparam int INDEX_WIDTH  = 10;
   localparam int VALUE_WIDTH  = 32;
   localparam int VLEN_WIDTH   = 11;
   localparam int ROW_WIDTH    = 16;
   localparam int ACC_WIDTH    = 48;
   localparam int PROD_WIDTH   = 2 * VALUE_WIDTH;
   localparam int FRAC_BITS    = 16;
   // Wide enough to compare any index against any store depth.
   localparam int CMP_WIDTH    = 17;

   // Input word kinds.
   localparam logic [KIND_WIDTH-1:0] KIND_LOAD    = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_NONZERO = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_EMPTY   = 2'd2;

   // Reset value of the vector length register.
   localparam logic [VLEN_WIDTH-1:0] VLEN_RESET = 11'd1024;

   // Clamp limits for the row sum.
   localparam logic [VALUE_WIDTH-1:0] SUM_MAX = 32'h7FFF_FFFF;
   localparam logic [VALUE_WIDTH-1:0] SUM_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]         kind;
      logic [INDEX_WIDTH-1:0]        index;
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          row_end;
   } req_word_type;

   typedef struct packed {
      logic [ROW_WIDTH-1:0]          row_index;
      logic signed [VALUE_WIDTH-1:0] row_sum;
      logic                          saturated;
      logic                          bad_column;
   } rsp_word_type;

   // Control bits that follow a word down the pipeline.
   typedef struct packed {
      logic [KIND_WIDTH-1:0] kind;
      logic                  row_end;
      logic                  col_ok;
   } ctrl_type;

   // Contents of the first stage, beside the vector read data.
   typedef struct packed {
      ctrl_type                      ctrl;
      logic signed [VALUE_WIDTH-1:0] value;
   } stage_type;

endpackage

/* rtl/csr_sparse_matvec_unit.sv */
// Channel  Direction  Handshake              Word
// req      in         req_valid / req_ready  req_word (kind, index, value, row_end)
// rsp      out        rsp_valid / rsp_ready  rsp_word (row_index, row_sum, saturated,
//                                            bad_column)
// csr      in         csr_valid / csr_ready  csr_data (vector length)
//
// One word is accepted per cycle while the consumer keeps up; a row result is valid once
// its last word has passed the store read, the product register and the output register.
// Reset is synchronous, clears the pipeline and row state and sets the vector length to
// 1024; the single-port vector store is not cleared and needs no sweep. While a result
// waits, words that end no row keep flowing; once a row-ending word waits in the second
// stage, at most one more word enters the first stage and req_ready then stays low.
module csr_sparse_matvec_unit #(
   parameter int VECTOR_DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  csrmv_pkg::req_word_type               req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output csrmv_pkg::rsp_word_type               rsp_word,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [csrmv_pkg::VLEN_WIDTH-1:0]      csr_data
);

   localparam int ADDR_WIDTH = $clog2(VECTOR_DEPTH);
   localparam logic [csrmv_pkg::CMP_WIDTH-1:0] DEPTH_LIMIT =
      csrmv_pkg::CMP_WIDTH'(VECTOR_DEPTH);

   logic [csrmv_pkg::VLEN_WIDTH-1:0]   vector_length_ff;
   logic                               s1_valid_ff;
   logic                               s1_valid_in;
   csrmv_pkg::stage_type               s1_stage_ff;
   csrmv_pkg::stage_type               s1_stage_in;
   logic                               s1_ready;
   logic                               req_fire;
   logic [csrmv_pkg::CMP_WIDTH-1:0]    index_wide;
   logic [csrmv_pkg::CMP_WIDTH-1:0]    length_wide;
   logic                               in_store;
   logic                               store_wr;
   logic                               store_rd;
   logic [ADDR_WIDTH-1:0]              store_addr;
   logic [csrmv_pkg::VALUE_WIDTH-1:0]  store_rd_data;

   // Configuration register; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= csrmv_pkg::VLEN_RESET;
      end else if (csr_valid) begin
         vector_length_ff <= csr_data;
      end
   end

   // Input acceptance and range checks on the index.
   assign req_ready   = !s1_valid_ff || s1_ready;
   assign req_fire    = req_valid && req_ready;
   assign index_wide  = csrmv_pkg::CMP_WIDTH'(req_word.index);
   assign length_wide = csrmv_pkg::CMP_WIDTH'(vector_length_ff);
   assign in_store    = index_wide < DEPTH_LIMIT;

   // Loads write the store; nonzeros read it.
   assign store_wr   = req_fire && (req_word.kind == csrmv_pkg::KIND_LOAD) && in_store;
   assign store_rd   = req_fire && (req_word.kind == csrmv_pkg::KIND_NONZERO) && in_store;
   assign store_addr = ADDR_WIDTH'(req_word.index);

   always_comb begin
      s1_stage_in.ctrl.kind    = req_word.kind;
      s1_stage_in.ctrl.row_end = req_word.row_end;
      s1_stage_in.ctrl.col_ok  = in_store && (index_wide < length_wide);
      s1_stage_in.value        = req_word.value;
   end

   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_stage_ff <= s1_stage_in;
      end
   end

   csrmv_vector_store #(
      .DEPTH (VECTOR_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .rd_en   (store_rd),
      .addr    (store_addr),
      .wr_data (req_word.value),
      .rd_data (store_rd_data)
   );

   csrmv_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid_ff),
      .s1_stage   (s1_stage_ff),
      .s1_rd_data (store_rd_data),
      .s1_ready   (s1_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

/* rtl/csrmv_vector_store.sv */
module csrmv_vector_store #(
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic                                  rd_en,
   input  logic [$clog2(DEPTH)-1:0]              addr,
   input  logic [csrmv_pkg::VALUE_WIDTH-1:0]     wr_data,
   output logic [csrmv_pkg::VALUE_WIDTH-1:0]     rd_data
);

   logic [csrmv_pkg::VALUE_WIDTH-1:0] vector_mem_ff [DEPTH];
   logic [csrmv_pkg::VALUE_WIDTH-1:0] rd_data_ff;

   // Single-port store with a registered read; a word either writes or reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vector_mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= vector_mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/csrmv_mac.sv */
module csrmv_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  s1_valid,
   input  csrmv_pkg::stage_type                  s1_stage,
   input  logic [csrmv_pkg::VALUE_WIDTH-1:0]     s1_rd_data,
   output logic                                  s1_ready,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output csrmv_pkg::rsp_word_type               rsp_word
);

   logic                                     s2_valid_ff;
   logic                                     s2_valid_in;
   csrmv_pkg::ctrl_type                      s2_ctrl_ff;
   logic signed [csrmv_pkg::PROD_WIDTH-1:0]  prod_ff;
   logic [csrmv_pkg::ACC_WIDTH-1:0]          acc_ff;
   logic [csrmv_pkg::ACC_WIDTH-1:0]          acc_in;
   logic                                     bad_ff;
   logic                                     bad_in;
   logic [csrmv_pkg::ROW_WIDTH-1:0]          row_count_ff;
   logic [csrmv_pkg::ROW_WIDTH-1:0]          row_count_in;
   logic                                     rsp_valid_ff;
   logic                                     rsp_valid_in;
   csrmv_pkg::rsp_word_type                  rsp_word_ff;
   csrmv_pkg::rsp_word_type                  rsp_word_in;
   logic                                     s2_emits;
   logic                                     s2_move;
   logic                                     s1_move;
   logic                                     out_load;
   logic                                     add_en;
   logic [csrmv_pkg::ACC_WIDTH-1:0]          add_term;
   logic [csrmv_pkg::ACC_WIDTH-1:0]          row_total;
   logic                                     row_bad;
   logic                                     sum_over;

   // A word in the second stage finishes a row on an empty marker or a nonzero row end.
   assign s2_emits = s2_valid_ff && ((s2_ctrl_ff.kind == csrmv_pkg::KIND_EMPTY) ||
                     ((s2_ctrl_ff.kind == csrmv_pkg::KIND_NONZERO) && s2_ctrl_ff.row_end));
   assign s2_move  = s2_valid_ff && (!s2_emits || !rsp_valid_ff || rsp_ready);
   assign s1_ready = !s2_valid_ff || s2_move;
   assign s1_move  = s1_valid && s1_ready;
   assign out_load = s2_move && s2_emits;

   // Multiply the nonzero by its vector entry; the product is registered.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_ctrl_ff <= s1_stage.ctrl;
         prod_ff    <= s1_stage.value * signed'(s1_rd_data);
      end
   end

   assign s2_valid_in = s1_move || (s2_valid_ff && !s2_move);

   // Drop the low fraction bits of the Q32.32 product and add into the row sum.
   assign add_en    = (s2_ctrl_ff.kind == csrmv_pkg::KIND_NONZERO) && s2_ctrl_ff.col_ok;
   assign add_term  = prod_ff[csrmv_pkg::PROD_WIDTH-1:csrmv_pkg::FRAC_BITS];
   assign row_total = acc_ff + (add_en ? add_term : '0);
   assign row_bad   = bad_ff ||
                      ((s2_ctrl_ff.kind == csrmv_pkg::KIND_NONZERO) && !s2_ctrl_ff.col_ok);

   // The sum fits in 32 bits only when its top bits are all copies of the sign.
   assign sum_over = (row_total[csrmv_pkg::ACC_WIDTH-1:csrmv_pkg::VALUE_WIDTH-1] != '0) &&
                     (row_total[csrmv_pkg::ACC_WIDTH-1:csrmv_pkg::VALUE_WIDTH-1] != '1);

   always_comb begin
      rsp_word_in.row_index  = row_count_ff;
      rsp_word_in.saturated  = sum_over;
      rsp_word_in.bad_column = row_bad;
      if (!sum_over) begin
         rsp_word_in.row_sum = row_total[csrmv_pkg::VALUE_WIDTH-1:0];
      end else if (row_total[csrmv_pkg::ACC_WIDTH-1]) begin
         rsp_word_in.row_sum = csrmv_pkg::SUM_MIN;
      end else begin
         rsp_word_in.row_sum = csrmv_pkg::SUM_MAX;
      end
   end

   // Row state update when the second stage word retires.
   always_comb begin
      acc_in       = acc_ff;
      bad_in       = bad_ff;
      row_count_in = row_count_ff;
      if (s2_move) begin
         case (s2_ctrl_ff.kind)
            csrmv_pkg::KIND_LOAD: begin
               acc_in       = '0;
               bad_in       = 1'b0;
               row_count_in = '0;
            end
            csrmv_pkg::KIND_NONZERO: begin
               if (s2_ctrl_ff.row_end) begin
                  acc_in       = '0;
                  bad_in       = 1'b0;
                  row_count_in = row_count_ff + 1'b1;
               end else begin
                  acc_in = row_total;
                  bad_in = row_bad;
               end
            end
            csrmv_pkg::KIND_EMPTY: begin
               acc_in       = '0;
               bad_in       = 1'b0;
               row_count_in = row_count_ff + 1'b1;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   // Output register; it holds a finished word until the consumer takes it.
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         bad_ff       <= 1'b0;
         row_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         acc_ff       <= acc_in;
         bad_ff       <= bad_in;
         row_count_ff <= row_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // A clamped sum is always one of the two limits.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.saturated) |->
         (rsp_word_ff.row_sum == csrmv_pkg::SUM_MAX ||
          rsp_word_ff.row_sum == csrmv_pkg::SUM_MIN))
      else $error("saturated row sum is not a clamp limit");

   // A retiring load restarts the row state.
   assert property (@(posedge clock) disable iff (reset)
      (s2_move && s2_ctrl_ff.kind == csrmv_pkg::KIND_LOAD) |=>
         (acc_ff == '0 && row_count_ff == '0 && !bad_ff))
      else $error("load did not restart the row state");

   // Each emitted row advances the row counter by one.
   assert property (@(posedge clock) disable iff (reset)
      out_load |=> (row_count_ff == 16'($past(row_count_ff) + 16'd1)))
      else $error("row counter did not advance with an emitted row");

endmodule
